// ===== design/spmq_pkg.sv =====
// ----------------------------------------------------------------------------
// spmq_pkg
// shared constants, types and helpers of the shared pool multi-queue
// ----------------------------------------------------------------------------
package spmq_pkg;

    localparam int POOL_CELLS   = 128;
    localparam int NUM_QUEUES   = 32;
    localparam int PAYLOAD_BITS = 64;

    localparam int QID_W    = 5;
    localparam int PAY_W    = 64;
    localparam int STAT_W   = 32;
    localparam int CELL_W   = (POOL_CELLS > 1) ? $clog2(POOL_CELLS) : 1;
    localparam int CNT_W    = $clog2(POOL_CELLS + 1);
    localparam int QUEUE_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    // request action codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef logic [CELL_W-1:0] t_cell;

    // controller to cell memory
    typedef struct packed {
        t_cell                   rd_addr;
        logic                    data_we;
        t_cell                   data_addr;
        logic [PAYLOAD_BITS-1:0] wr_payload;
        logic [STAT_W-1:0]       wr_status;
        logic                    link_we;
        t_cell                   link_addr;
        t_cell                   link_data;
    } t_mem_req;

    // cell memory to controller, registered from rd_addr
    typedef struct packed {
        t_cell                   link;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [STAT_W-1:0]       status;
    } t_mem_rsp;

    // finished request from the controller
    typedef struct packed {
        logic              valid;
        logic              ok;
        logic [PAY_W-1:0]  payload;
        logic [STAT_W-1:0] status;
    } t_result;

    // default successor of a cell in the free list after reset
    function automatic t_cell cell_next(input t_cell c);
        t_cell nxt;
        if (c == CELL_W'(POOL_CELLS - 1)) begin
            nxt = '0;
        end else begin
            nxt = c + CELL_W'(1);
        end
        return nxt;
    endfunction

endpackage

// ===== design/spmq_cell_mem.sv =====
// ----------------------------------------------------------------------------
// spmq_cell_mem
// cell storage: payload, status and link memories, one registered read port
// ----------------------------------------------------------------------------
module spmq_cell_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spmq_pkg::t_mem_req i_req,
    output spmq_pkg::t_mem_rsp o_rsp
);

    logic [spmq_pkg::PAYLOAD_BITS-1:0] r_payload_mem [spmq_pkg::POOL_CELLS];
    logic [spmq_pkg::STAT_W-1:0]       r_status_mem  [spmq_pkg::POOL_CELLS];
    spmq_pkg::t_cell                   r_link_mem    [spmq_pkg::POOL_CELLS];

    // a link never written reads as its reset successor
    logic [spmq_pkg::POOL_CELLS-1:0]   r_link_vld;

    logic [spmq_pkg::PAYLOAD_BITS-1:0] r_rd_payload;
    logic [spmq_pkg::STAT_W-1:0]       r_rd_status;
    spmq_pkg::t_cell                   r_rd_link;
    logic                              r_rd_vld;
    spmq_pkg::t_cell                   r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_req.data_we) begin
            r_payload_mem[i_req.data_addr] <= i_req.wr_payload;
            r_status_mem[i_req.data_addr]  <= i_req.wr_status;
        end
        if (i_req.link_we) begin
            r_link_mem[i_req.link_addr] <= i_req.link_data;
        end
        r_rd_payload <= r_payload_mem[i_req.rd_addr];
        r_rd_status  <= r_status_mem[i_req.rd_addr];
        r_rd_link    <= r_link_mem[i_req.rd_addr];
        r_rd_addr    <= i_req.rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_rd_vld <= r_link_vld[i_req.rd_addr];
            if (i_req.link_we) begin
                r_link_vld[i_req.link_addr] <= 1'b1;
            end
        end
    end

    always_comb begin
        o_rsp.payload = r_rd_payload;
        o_rsp.status  = r_rd_status;
        o_rsp.link    = r_rd_vld ? r_rd_link : spmq_pkg::cell_next(r_rd_addr);
    end

endmodule

// ===== design/spmq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spmq_ctrl
// queue head/tail tables, free list and the two-step request sequencer
// ----------------------------------------------------------------------------
module spmq_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_action,
    input  logic [spmq_pkg::QID_W-1:0]  i_queue_id,
    input  logic [spmq_pkg::PAY_W-1:0]  i_payload_in,
    input  logic [spmq_pkg::STAT_W-1:0] i_status_in,
    output logic                        o_busy,
    output spmq_pkg::t_mem_req          o_mem_req,
    input  spmq_pkg::t_mem_rsp          i_mem_rsp,
    output spmq_pkg::t_result           o_result
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    spmq_pkg::t_cell                  r_head     [spmq_pkg::NUM_QUEUES];
    spmq_pkg::t_cell                  r_tail     [spmq_pkg::NUM_QUEUES];
    logic [spmq_pkg::NUM_QUEUES-1:0]  r_nonempty;
    spmq_pkg::t_cell                  r_free_head, n_free_head;
    logic [spmq_pkg::CNT_W-1:0]       r_free_count, n_free_count;
    logic                             r_action;
    logic [spmq_pkg::QID_W-1:0]       r_qid;

    logic [spmq_pkg::QID_W-1:0]   qid_sel;
    logic [spmq_pkg::QUEUE_W-1:0] qidx;
    logic                         q_in_range;
    logic                         accept;
    logic                         pool_has_free;
    logic                         enq_ok;
    logic                         deq_ok;
    spmq_pkg::t_cell              sel_head;
    spmq_pkg::t_cell              sel_tail;
    logic                         sel_nonempty;
    logic                         deq_last;

    assign accept        = i_start && (r_state == ST_IDLE);
    assign o_busy        = (r_state == ST_EXEC);
    // single table read port: new request while idle, latched one otherwise
    assign qid_sel       = o_busy ? r_qid : i_queue_id;
    assign qidx          = qid_sel[spmq_pkg::QUEUE_W-1:0];
    assign q_in_range    = (32'(qid_sel) < spmq_pkg::NUM_QUEUES);
    assign sel_head      = r_head[qidx];
    assign sel_tail      = r_tail[qidx];
    assign sel_nonempty  = r_nonempty[qidx];
    assign pool_has_free = (r_free_count != '0);

    assign enq_ok   = o_busy && (r_action == spmq_pkg::ACT_ENQ) && q_in_range && pool_has_free;
    assign deq_ok   = o_busy && (r_action == spmq_pkg::ACT_DEQ) && q_in_range && sel_nonempty;
    assign deq_last = (sel_head == sel_tail);

    always_comb begin
        o_mem_req            = '0;
        o_mem_req.rd_addr    = (i_action == spmq_pkg::ACT_DEQ) ? sel_head : r_free_head;
        // enqueue cell data is written at accept, into the cell at the free-list head
        o_mem_req.data_we    = accept && (i_action == spmq_pkg::ACT_ENQ) && q_in_range
                               && pool_has_free;
        o_mem_req.data_addr  = r_free_head;
        o_mem_req.wr_payload = i_payload_in[spmq_pkg::PAYLOAD_BITS-1:0];
        o_mem_req.wr_status  = i_status_in;
        if (enq_ok && sel_nonempty) begin
            o_mem_req.link_we   = 1'b1;
            o_mem_req.link_addr = sel_tail;
            o_mem_req.link_data = r_free_head;
        end else if (deq_ok) begin
            o_mem_req.link_we   = 1'b1;
            o_mem_req.link_addr = sel_head;
            o_mem_req.link_data = r_free_head;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                if (enq_ok) begin
                    n_free_head  = i_mem_rsp.link;
                    n_free_count = r_free_count - spmq_pkg::CNT_W'(1);
                end else if (deq_ok) begin
                    n_free_head = sel_head;
                    if (r_free_count < spmq_pkg::CNT_W'(spmq_pkg::POOL_CELLS)) begin
                        n_free_count = r_free_count + spmq_pkg::CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_free_head  <= '0;
            r_free_count <= spmq_pkg::CNT_W'(spmq_pkg::POOL_CELLS);
            r_nonempty   <= '0;
            for (int i = 0; i < spmq_pkg::NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_free_count <= n_free_count;
            if (enq_ok) begin
                if (!sel_nonempty) begin
                    r_head[qidx] <= r_free_head;
                end
                r_tail[qidx]     <= r_free_head;
                r_nonempty[qidx] <= 1'b1;
            end else if (deq_ok) begin
                if (deq_last) begin
                    r_nonempty[qidx] <= 1'b0;
                end else begin
                    r_head[qidx] <= i_mem_rsp.link;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_qid    <= i_queue_id;
        end
    end

    always_comb begin
        o_result.valid   = o_busy;
        o_result.ok      = enq_ok || deq_ok;
        o_result.payload = deq_ok ? spmq_pkg::PAY_W'(i_mem_rsp.payload) : '0;
        o_result.status  = deq_ok ? i_mem_rsp.status : '0;
    end

endmodule

// ===== design/shared_pool_multi_queue.sv =====
// ----------------------------------------------------------------------------
// shared_pool_multi_queue
// linked-list FIFOs for many queues sharing one pool of cells
// ----------------------------------------------------------------------------
// usage
//   request channel: drive i_action, i_queue_id, i_payload_in, i_status_in
//   and raise start; the request is taken at a rising edge where start is
//   high and busy is low. i_action low enqueues, high dequeues.
//   result channel: o_done is high for exactly one cycle per request, with
//   o_ok, o_payload_out and o_status_out valid in that cycle. there is no
//   backpressure: the receiver must take the result in that cycle.
//   o_ok low means pool full on enqueue or queue empty on dequeue; payload
//   and status read zero on enqueue and on failure.
// timing
//   the result strobe is registered from the exec state that the accepting
//   edge enters. busy is high only while in exec, so no new request is
//   taken in exec, but one can be taken at the edge that ends the cycle
//   where the previous result is shown. exec is needed as the cell
//   memory is synchronous: the head (or free-list head) cell is read at
//   accept, and its link, needed for the new head pointer, is used and
//   written back in exec.
// reset
//   synchronous, active low; all queues come up empty and every cell is on
//   the free list in index order. no clearing pass is needed, link entries
//   not yet written read as their reset successor.
// ----------------------------------------------------------------------------
module shared_pool_multi_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_action,
    input  logic [spmq_pkg::QID_W-1:0]         i_queue_id,
    input  logic [spmq_pkg::PAY_W-1:0]         i_payload_in,
    input  logic signed [spmq_pkg::STAT_W-1:0] i_status_in,
    output logic                               o_done,
    output logic                               o_ok,
    output logic [spmq_pkg::PAY_W-1:0]         o_payload_out,
    output logic signed [spmq_pkg::STAT_W-1:0] o_status_out
);

    spmq_pkg::t_mem_req mem_req;
    spmq_pkg::t_mem_rsp mem_rsp;
    spmq_pkg::t_result  result;

    // request sequencer, queue tables and free list
    spmq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_action     (i_action),
        .i_queue_id   (i_queue_id),
        .i_payload_in (i_payload_in),
        .i_status_in  (i_status_in),
        .o_busy       (busy),
        .o_mem_req    (mem_req),
        .i_mem_rsp    (mem_rsp),
        .o_result     (result)
    );

    // cell payload, status and link storage
    spmq_cell_mem u_cell_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    // result register: strobe is cleared by reset, data follows the strobe
    logic                        r_done;
    logic                        r_ok;
    logic [spmq_pkg::PAY_W-1:0]  r_payload;
    logic [spmq_pkg::STAT_W-1:0] r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_ok      <= result.ok;
            r_payload <= result.payload;
            r_status  <= result.status;
        end
    end

    assign o_done        = r_done;
    assign o_ok          = r_ok;
    assign o_payload_out = r_payload;
    assign o_status_out  = r_status;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the shared pool multi-queue against a cycle-free model of its lists
// ----------------------------------------------------------------------------
// requests are built up front into a queue: a short directed set first, then
// random traffic that swings between filling the pool until it refuses
// enqueues and draining it until every queue is empty again. the driver hands
// requests to the block in bursts with random gaps. each accepted request is
// run through the model at the accepting edge, and the monitor compares every
// strobed result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_REQUESTS = 650;
    localparam int CYCLE_LIMIT     = 100000;
    localparam int TAIL_CYCLES     = 8;
    localparam logic [spmq_pkg::PAY_W-1:0] PAY_MASK =
        (spmq_pkg::PAYLOAD_BITS >= spmq_pkg::PAY_W) ? {spmq_pkg::PAY_W{1'b1}} :
        ((spmq_pkg::PAY_W'(1) << spmq_pkg::PAYLOAD_BITS) - spmq_pkg::PAY_W'(1));

    typedef struct {
        logic                               action;
        logic [spmq_pkg::QID_W-1:0]         queue_id;
        logic [spmq_pkg::PAY_W-1:0]         payload;
        logic signed [spmq_pkg::STAT_W-1:0] status;
    } t_pool_req;

    typedef struct {
        logic                               ok;
        logic [spmq_pkg::PAY_W-1:0]         payload;
        logic signed [spmq_pkg::STAT_W-1:0] status;
    } t_pool_rsp;

    // dut ports; the inputs are known from time zero
    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               start         = 1'b0;
    logic                               busy;
    logic                               i_action      = spmq_pkg::ACT_ENQ;
    logic [spmq_pkg::QID_W-1:0]         i_queue_id    = '0;
    logic [spmq_pkg::PAY_W-1:0]         i_payload_in  = '0;
    logic signed [spmq_pkg::STAT_W-1:0] i_status_in   = '0;
    logic                               o_done;
    logic                               o_ok;
    logic [spmq_pkg::PAY_W-1:0]         o_payload_out;
    logic signed [spmq_pkg::STAT_W-1:0] o_status_out;

    // request and result stores
    t_pool_req pending_requests[$];
    t_pool_rsp awaited_results[$];
    t_pool_req cur_req;
    int        total_requests = 0;
    int        requests_taken = 0;
    int        mismatches     = 0;
    int        cycle_count    = 0;

    // model of the pool: cell contents, links, per-queue pointers, free list
    logic [spmq_pkg::PAY_W-1:0]  cell_pay  [spmq_pkg::POOL_CELLS];
    logic [spmq_pkg::STAT_W-1:0] cell_stat [spmq_pkg::POOL_CELLS];
    spmq_pkg::t_cell             cell_nxt  [spmq_pkg::POOL_CELLS];
    spmq_pkg::t_cell             q_head    [spmq_pkg::NUM_QUEUES];
    spmq_pkg::t_cell             q_tail    [spmq_pkg::NUM_QUEUES];
    logic                        q_live    [spmq_pkg::NUM_QUEUES];
    spmq_pkg::t_cell             free_hd;
    logic [spmq_pkg::CNT_W-1:0]  free_cnt;

    // occupancy as seen by the stimulus builder, used only to steer traffic
    int gen_depth [spmq_pkg::NUM_QUEUES];
    int gen_used   = 0;
    int full_hits  = 0;

    // sender burst / gap pacing
    int burst_left = 1;
    int idle_left  = 0;

    shared_pool_multi_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_queue_id    (i_queue_id),
        .i_payload_in  (i_payload_in),
        .i_status_in   (i_status_in),
        .o_done        (o_done),
        .o_ok          (o_ok),
        .o_payload_out (o_payload_out),
        .o_status_out  (o_status_out)
    );

    always #1 i_clk = ~i_clk;

    // apply one accepted request to the model and return what the block owes
    function automatic t_pool_rsp apply_pool_request(input t_pool_req r);
        t_pool_rsp       rsp;
        spmq_pkg::t_cell c;
        rsp.ok      = 1'b0;
        rsp.payload = '0;
        rsp.status  = '0;
        if (int'(r.queue_id) < spmq_pkg::NUM_QUEUES) begin
            if (r.action == spmq_pkg::ACT_ENQ) begin
                // pool full: refused, nothing moves
                if (free_cnt != 0) begin
                    c         = free_hd;
                    free_hd   = cell_nxt[c];
                    free_cnt  = free_cnt - 1'b1;
                    cell_pay[c]  = r.payload & PAY_MASK;
                    cell_stat[c] = r.status;
                    if (q_live[r.queue_id]) begin
                        cell_nxt[q_tail[r.queue_id]] = c;
                    end else begin
                        q_head[r.queue_id] = c;
                    end
                    q_tail[r.queue_id] = c;
                    q_live[r.queue_id] = 1'b1;
                    rsp.ok = 1'b1;
                end
            end else if (q_live[r.queue_id]) begin
                // unlink the head cell and push it onto the free list
                c           = q_head[r.queue_id];
                rsp.payload = cell_pay[c];
                rsp.status  = cell_stat[c];
                if (c == q_tail[r.queue_id]) begin
                    q_live[r.queue_id] = 1'b0;
                end else begin
                    q_head[r.queue_id] = cell_nxt[c];
                end
                cell_nxt[c] = free_hd;
                free_hd     = c;
                if (free_cnt < spmq_pkg::POOL_CELLS) begin
                    free_cnt = free_cnt + 1'b1;
                end
                rsp.ok = 1'b1;
            end
        end
        return rsp;
    endfunction

    task automatic report_mismatch(input string field,
                                   input logic [spmq_pkg::PAY_W-1:0] want,
                                   input logic [spmq_pkg::PAY_W-1:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endtask

    // append a request and track occupancy so later picks stay meaningful
    task automatic queue_request(input logic act, input int qid,
                                 input logic [spmq_pkg::PAY_W-1:0] pay,
                                 input logic [spmq_pkg::STAT_W-1:0] st);
        t_pool_req r;
        r.action   = act;
        r.queue_id = spmq_pkg::QID_W'(qid);
        r.payload  = pay;
        r.status   = st;
        pending_requests.push_back(r);
        total_requests++;
        if (act == spmq_pkg::ACT_ENQ) begin
            if (gen_used < spmq_pkg::POOL_CELLS) begin
                gen_used++;
                gen_depth[qid]++;
            end else begin
                full_hits++;
            end
        end else if (gen_depth[qid] != 0) begin
            gen_depth[qid]--;
            gen_used--;
        end
    endtask

    // mostly random bits, now and then all zeros or all ones
    function automatic logic [spmq_pkg::PAY_W-1:0] rand_word();
        logic [spmq_pkg::PAY_W-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = '1;
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // half the traffic lands on a few queues so their lists grow long
    function automatic int pick_queue();
        int q;
        if ($urandom_range(0, 1) == 1) begin
            q = $urandom_range(0, 3) * 9;
        end else begin
            q = $urandom_range(0, spmq_pkg::NUM_QUEUES - 1);
        end
        return q;
    endfunction

    // driver: present requests in bursts, hold each until start meets !busy
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                awaited_results.push_back(apply_pool_request(cur_req));
                requests_taken++;
            end
            if (start && busy) begin
                // request still waiting, keep it on the ports
            end else if (idle_left != 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                cur_req      = pending_requests.pop_front();
                i_action     <= cur_req.action;
                i_queue_id   <= cur_req.queue_id;
                i_payload_in <= cur_req.payload;
                i_status_in  <= cur_req.status;
                start        <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left--;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every strobe must match the oldest outstanding prediction
    always @(posedge i_clk) begin
        t_pool_rsp want;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unrequested result", '0, o_payload_out);
            end else begin
                want = awaited_results.pop_front();
                if (o_ok !== want.ok) begin
                    report_mismatch("ok", spmq_pkg::PAY_W'(want.ok),
                                    spmq_pkg::PAY_W'(o_ok));
                end
                if (o_payload_out !== want.payload) begin
                    report_mismatch("payload", want.payload, o_payload_out);
                end
                if (o_status_out !== want.status) begin
                    report_mismatch("status", spmq_pkg::PAY_W'(want.status),
                                    spmq_pkg::PAY_W'(o_status_out));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int  n;
        int  k;
        int  qid;
        int  full_mark;
        bit  filling;
        bit  enq;

        // model comes up like the block: queues empty, cells chained in order
        for (n = 0; n < spmq_pkg::POOL_CELLS; n++) begin
            cell_pay[n]  = '0;
            cell_stat[n] = '0;
            cell_nxt[n]  = spmq_pkg::t_cell'((n + 1) % spmq_pkg::POOL_CELLS);
        end
        for (n = 0; n < spmq_pkg::NUM_QUEUES; n++) begin
            q_head[n]    = '0;
            q_tail[n]    = '0;
            q_live[n]    = 1'b0;
            gen_depth[n] = 0;
        end
        free_hd  = '0;
        free_cnt = spmq_pkg::CNT_W'(spmq_pkg::POOL_CELLS);

        // directed: field extremes, both actions, empty-queue dequeues
        queue_request(spmq_pkg::ACT_DEQ, 0, '1, '1);
        queue_request(spmq_pkg::ACT_ENQ, 0, '0, '0);
        queue_request(spmq_pkg::ACT_ENQ, 0, '1, 32'h7fff_ffff);
        queue_request(spmq_pkg::ACT_ENQ, spmq_pkg::NUM_QUEUES - 1,
                      64'h8000_0000_0000_0001, 32'h8000_0000);
        queue_request(spmq_pkg::ACT_ENQ, spmq_pkg::NUM_QUEUES - 1,
                      64'h5555_5555_5555_5555, 32'hffff_ffff);
        queue_request(spmq_pkg::ACT_DEQ, 5, '0, '0);
        queue_request(spmq_pkg::ACT_DEQ, 0, '0, '0);
        queue_request(spmq_pkg::ACT_ENQ, 0, 64'haaaa_aaaa_aaaa_aaaa, 32'h5555_aaaa);
        queue_request(spmq_pkg::ACT_DEQ, 0, '0, '0);
        queue_request(spmq_pkg::ACT_DEQ, 0, '0, '0);
        queue_request(spmq_pkg::ACT_DEQ, 0, '0, '0);
        queue_request(spmq_pkg::ACT_DEQ, spmq_pkg::NUM_QUEUES - 1, '1, '1);
        queue_request(spmq_pkg::ACT_DEQ, spmq_pkg::NUM_QUEUES - 1, '1, '1);
        queue_request(spmq_pkg::ACT_DEQ, spmq_pkg::NUM_QUEUES - 1, '1, '1);
        queue_request(spmq_pkg::ACT_ENQ, 7, 64'h0123_4567_89ab_cdef, 32'h0000_0001);
        queue_request(spmq_pkg::ACT_ENQ, 21, 64'hfedc_ba98_7654_3210, 32'hffff_fffe);
        queue_request(spmq_pkg::ACT_DEQ, 21, '0, '0);
        queue_request(spmq_pkg::ACT_DEQ, 7, '0, '0);
        queue_request(spmq_pkg::ACT_DEQ, 7, '0, '0);

        // random: fill until the pool refuses at least four enqueues, then drain
        filling   = 1'b1;
        full_mark = full_hits;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (filling && gen_used == spmq_pkg::POOL_CELLS
                && full_hits - full_mark >= 4) begin
                filling = 1'b0;
            end
            if (!filling && gen_used == 0) begin
                filling   = 1'b1;
                full_mark = full_hits;
            end
            enq = ($urandom_range(0, 99) < (filling ? 75 : 25));
            qid = pick_queue();
            if (enq) begin
                queue_request(spmq_pkg::ACT_ENQ, qid, rand_word(),
                              spmq_pkg::STAT_W'(rand_word()));
            end else begin
                // usually aim at a queue that holds something
                if ($urandom_range(0, 9) != 0) begin
                    for (k = 0; k < spmq_pkg::NUM_QUEUES; k++) begin
                        if (gen_depth[(qid + k) % spmq_pkg::NUM_QUEUES] != 0) begin
                            qid = (qid + k) % spmq_pkg::NUM_QUEUES;
                            break;
                        end
                    end
                end
                queue_request(spmq_pkg::ACT_DEQ, qid, rand_word(),
                              spmq_pkg::STAT_W'(rand_word()));
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request to go in and every result to come back
        while (requests_taken != total_requests) @(negedge i_clk);
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
